/* src/dkht_pkg.sv */
// Package for the dual-key chained hash table: request and status codes,
// and the queue entry passed from the front end to the engine. No dependencies.
`default_nettype none
package dkht_pkg;
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_t;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  typedef struct packed {
    req_t              req;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  key_sum;
  } cmd_t;
endpackage
`default_nettype wire

/* src/dkht_front.sv */
// Front end: accepts requests, forms the key sum and holds them in a short
// queue for the engine. Depends on dkht_pkg.
`default_nettype none
module dkht_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    req_type,
  input  wire logic [31:0]   key_a,
  input  wire logic [31:0]   key_b,
  input  wire logic [31:0]   data_in,
  output logic               cmd_valid,
  input  wire logic          cmd_take,
  output dkht_pkg::cmd_t     cmd
);
  import dkht_pkg::*;

  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wp] <= '{req: req_t'(req_type), key_a: key_a, key_b: key_b,
                 data: data_in, key_sum: key_a + key_b};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (cmd_take && cmd_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, push && !full} - {1'b0, cmd_take && cmd_valid};
    end
  end
endmodule
`default_nettype wire

/* src/dkht_engine.sv */
// Back end: bucket select by iterative modulo, chain walk over node memories,
// free list upkeep, clearing sweeps and a two-entry result queue. Uses dkht_pkg.
`default_nettype none
module dkht_engine #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        cmd_valid,
  output logic             cmd_take,
  input  wire dkht_pkg::cmd_t cmd,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [31:0]      data_out,
  output logic [6:0]       entries_held
);
  import dkht_pkg::*;

  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int SW = (MAX_BUCKETS > POOL_NODES) ? BW + 1 : NW + 1;
  localparam logic [LW-1:0] NONE = LW'(POOL_NODES);
  localparam logic [6:0] MAXB7 = (MAX_BUCKETS > 127) ? 7'd127 : 7'(MAX_BUCKETS);
  localparam logic [6:0] RESET_BUCKETS = (MAX_BUCKETS < 64) ? 7'(MAX_BUCKETS) : 7'd64;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_CMP, S_NEXT,
    S_UNLINK, S_FREE, S_SWEEP, S_DONE
  } state_t;

  logic [LW-1:0] bucket_head [MAX_BUCKETS];
  logic [LW-1:0] node_next [POOL_NODES];
  logic [31:0]   node_ka [POOL_NODES];
  logic [31:0]   node_kb [POOL_NODES];
  logic [31:0]   node_dat [POOL_NODES];

  state_t        state;
  cmd_t          c;
  logic [6:0]    bucket_count, nb;
  logic [31:0]   rem;
  logic [5:0]    mod_i;
  logic [BW-1:0] bkt;
  logic [LW-1:0] cur, prev, free_head, rd_next, rd_head;
  logic [31:0]   rd_ka, rd_kb, rd_dat;
  logic [LW:0]   steps;
  logic [6:0]    entry_count;
  logic [SW-1:0] sweep;
  logic          sweep_reply;
  logic [1:0]    res_status;
  logic [31:0]   res_data;

  // result queue
  logic [40:0]   rq [2];
  logic          rwp, rrp;
  logic [1:0]    rcnt;
  logic          res_push;

  assign nb        = (bucket_count > MAXB7) ? MAXB7 : bucket_count;
  assign cfg_ready = (state == S_IDLE) && !cmd_valid;
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign empty     = (rcnt == 2'd0);
  assign {status, data_out, entries_held} = rq[rrp];
  assign res_push  = (state == S_DONE) && (rcnt != 2'd2);

  // Restoring modulo, one quotient bit per cycle.
  logic [31:0] shifted_nb;
  assign shifted_nb = 32'({25'd0, nb}) << mod_i;
  logic fits;
  assign fits = ({7'd0, rem} >= {7'd0, shifted_nb}) &&
                ((39'({32'd0, nb}) << mod_i) <= 39'(rem));

  always_ff @(posedge clk) begin
    rd_next <= node_next[NW'(cur)];
    rd_ka   <= node_ka[NW'(cur)];
    rd_kb   <= node_kb[NW'(cur)];
    rd_dat  <= node_dat[NW'(cur)];
    rd_head <= bucket_head[bkt];
    if (res_push) rq[rwp] <= {res_status, res_data, entry_count};
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      sweep_reply <= 1'b0;
      bucket_count <= RESET_BUCKETS;
      free_head <= '0;
      entry_count <= '0;
      rwp <= 1'b0;
      rrp <= 1'b0;
      rcnt <= 2'd0;
    end else begin
      if (res_push) rwp <= ~rwp;
      if (pop && !empty) rrp <= ~rrp;
      rcnt <= rcnt + {1'b0, res_push} - {1'b0, pop && !empty};
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            bucket_count <= cfg_data;
            sweep <= '0;
            sweep_reply <= 1'b0;
            state <= S_SWEEP;
          end else if (cmd_take) begin
            c <= cmd;
            res_data <= '0;
            res_status <= ST_OK;
            rem <= cmd.key_sum;
            mod_i <= 6'd32;
            if (nb == 7'd0) begin
              res_status <= ST_NO_TABLE;
              state <= S_DONE;
            end else if (cmd.req == REQ_CLEAR) begin
              sweep <= '0;
              sweep_reply <= 1'b1;
              state <= S_SWEEP;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (fits) rem <= rem - shifted_nb;
          if (mod_i == 6'd0) state <= S_HEAD;
          else mod_i <= mod_i - 6'd1;
        end
        S_HEAD: begin
          bkt <= BW'(rem);
          if (c.req == REQ_ADD) begin
            if (free_head == NONE) begin
              res_status <= ST_FULL;
              state <= S_DONE;
            end else begin
              cur <= free_head;
              state <= S_HEADW;
            end
          end else begin
            state <= S_HEADW;
          end
        end
        S_HEADW: begin
          // rd_head is registered from bkt here and is valid in S_NODE
          state <= S_NODE;
        end
        S_NODE: begin
          if (c.req == REQ_ADD) begin
            // rd_next holds next of the free node
            free_head <= rd_next;
            node_ka[NW'(cur)] <= c.key_a;
            node_kb[NW'(cur)] <= c.key_b;
            node_dat[NW'(cur)] <= c.data;
            node_next[NW'(cur)] <= rd_head;
            bucket_head[bkt] <= cur;
            entry_count <= entry_count + 7'd1;
            state <= S_DONE;
          end else begin
            cur <= rd_head;
            prev <= NONE;
            steps <= '0;
            state <= S_NODEW;
          end
        end
        S_NODEW: begin
          if (cur >= NONE || steps >= (LW+1)'(POOL_NODES)) begin
            res_status <= ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_ka == c.key_a && rd_kb == c.key_b) begin
            res_data <= rd_dat;
            state <= (c.req == REQ_REMOVE) ? S_UNLINK : S_DONE;
          end else begin
            prev <= cur;
            cur <= rd_next;
            steps <= steps + 1'b1;
            state <= S_NEXT;
          end
        end
        S_NEXT: state <= S_NODEW;
        S_UNLINK: begin
          if (prev != NONE) node_next[NW'(prev)] <= rd_next;
          else bucket_head[bkt] <= rd_next;
          state <= S_FREE;
        end
        S_FREE: begin
          node_next[NW'(cur)] <= free_head;
          free_head <= cur;
          if (entry_count != 7'd0) entry_count <= entry_count - 7'd1;
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (sweep < SW'(MAX_BUCKETS)) bucket_head[BW'(sweep)] <= NONE;
          if (sweep < SW'(POOL_NODES)) node_next[NW'(sweep)] <= LW'(sweep) + 1'b1;
          free_head <= '0;
          entry_count <= '0;
          if (sweep == SW'((MAX_BUCKETS > POOL_NODES) ? MAX_BUCKETS - 1 : POOL_NODES - 1))
            state <= sweep_reply ? S_DONE : S_IDLE;
          sweep <= sweep + 1'b1;
        end
        S_DONE: if (rcnt != 2'd2) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/dual_key_chained_hash_table.sv */
// Top level of the dual-key chained hash table: joins the request front end
// and the table engine. Depends on dkht_pkg, dkht_front and dkht_engine.
//
// Usage: requests enter on push/full as a queue; results leave on empty/pop
// with the oldest result on status, data_out and entries_held while empty
// is low. bucket_count is written on cfg_valid/cfg_ready; ready is given
// only while the engine is idle with no request queued, and a write
// empties the table.
// Request flow: the bucket is found by a restoring modulo of the key sum
// (one quotient bit per cycle); an add then links a free node at the head
// of its chain, a lookup walks the chain node by node, and a remove that
// hits also unlinks its node and returns it to the free list. A request
// with no table skips the modulo and answers with ST_NO_TABLE. Requests
// are handled one at a time; the next one is taken once the previous
// result has been queued. Clear and every bucket_count write run a
// clearing sweep over all bucket heads and pool nodes.
// Reset runs the same sweep. When the result queue is full the engine
// holds its result and stops, and the two-entry request queue then fills
// and raises full.
`default_nettype none
module dual_key_chained_hash_table #(
  parameter int MAX_BUCKETS = 64,
  parameter int POOL_NODES  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] key_a,
  input  wire logic [31:0] key_b,
  input  wire logic [31:0] data_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [31:0]      data_out,
  output logic [6:0]       entries_held,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);
  import dkht_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  dkht_front u_front (
    .clk, .rst, .push, .full, .req_type, .key_a, .key_b, .data_in,
    .cmd_valid, .cmd_take, .cmd
  );

  dkht_engine #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_engine (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .cmd_valid, .cmd_take, .cmd,
    .empty, .pop, .status, .data_out, .entries_held
  );
endmodule
`default_nettype wire
